// ----- src/lmdd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmdd_pkg: shared types for the lock manager.
// Request and result structs, opcode and status codes, controller commands.
// ----------------------------------------------------------------------------
package lmdd_pkg;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_TRY     = 2'd3
  } opcode_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_TRYFAIL = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] pid;
    logic [3:0] lock_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       deadlock;
    logic       woke;
    logic [3:0] woken_pid;
    logic [3:0] new_lock_id;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request
    logic execute;    // perform the request and form the result
    logic walk_step;  // advance the wait-for walk by one lock
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_walk;  // request blocked, walk must run
    logic walk_done;  // walk finished this step
  } sts_t;

endpackage

// ----- src/lmdd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmdd_ctrl: request sequencer.
// Loads a request, executes it, runs the deadlock walk if needed, then
// strobes the result.
// ----------------------------------------------------------------------------
module lmdd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output lmdd_pkg::cmd_t    cmd,
  input  lmdd_pkg::sts_t    sts
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK} state_t;

  state_t state;

  always_comb begin
    cmd.load      = (state == S_IDLE) && start;
    cmd.execute   = (state == S_EXEC);
    cmd.walk_step = (state == S_WALK);
    busy          = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) state <= S_EXEC;
        end
        S_EXEC: begin
          if (sts.need_walk) begin
            state <= S_WALK;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_WALK: begin
          if (sts.walk_done) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/lmdd_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmdd_dpath: lock and process tables with the wait-for walk.
// Executes one request per execute command; walks one lock per step.
// ----------------------------------------------------------------------------
module lmdd_dpath #(
  parameter int MAX_LOCKS = 16,
  parameter int NUM_PROCS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  lmdd_pkg::req_t   req,
  input  lmdd_pkg::cmd_t   cmd,
  output lmdd_pkg::sts_t   sts,
  output lmdd_pkg::rsp_t   rsp
);

  localparam int LCW = $clog2(MAX_LOCKS + 1);
  localparam int SCW = $clog2(MAX_LOCKS + 1);

  logic [LCW-1:0] lock_count;
  logic [MAX_LOCKS-1:0] lock_held;
  logic [MAX_LOCKS-1:0] queue_nonempty;
  logic [3:0] lock_owner [MAX_LOCKS];
  logic [3:0] queue_head [MAX_LOCKS];
  logic [3:0] queue_tail [MAX_LOCKS];
  logic [NUM_PROCS-1:0] proc_waiting;
  logic [3:0] proc_wait_lock [NUM_PROCS];
  logic [3:0] proc_next [NUM_PROCS];

  lmdd_pkg::req_t r;
  logic [3:0]     walk_lock;
  logic [SCW-1:0] walk_cnt;

  // Range checks done at full width.
  logic lk_ok, pid_ok, err;
  logic [3:0] own_w;
  logic w_lk_ok, w_own_ok;
  logic [3:0] head, tail;

  always_comb begin
    lk_ok  = (32'(r.lock_id) < 32'(lock_count)) && (32'(r.lock_id) < MAX_LOCKS);
    pid_ok = 32'(r.pid) < NUM_PROCS;
    err    = !lk_ok || !pid_ok || proc_waiting[pid_ok ? r.pid : 4'd0];
    head   = queue_head[r.lock_id];
    tail   = queue_tail[r.lock_id];
    w_lk_ok  = 32'(walk_lock) < MAX_LOCKS;
    own_w    = w_lk_ok ? lock_owner[walk_lock] : 4'd0;
    w_own_ok = 32'(own_w) < NUM_PROCS;
    sts.need_walk = cmd.execute && !err && (r.opcode == lmdd_pkg::OP_ACQUIRE)
                    && lock_held[r.lock_id];
    sts.walk_done = !w_lk_ok || (own_w == 4'd0) || (own_w == r.pid) ||
                    !w_own_ok || !proc_waiting[own_w] ||
                    (32'(walk_cnt) == MAX_LOCKS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_count     <= '0;
      lock_held      <= '0;
      queue_nonempty <= '0;
      proc_waiting   <= '0;
      for (int i = 0; i < MAX_LOCKS; i++) lock_owner[i] <= 4'd0;
    end else begin
      if (cmd.load) r <= req;
      if (cmd.execute) begin
        rsp <= '0;
        if (r.opcode == lmdd_pkg::OP_CREATE) begin
          if (32'(lock_count) >= MAX_LOCKS) begin
            rsp.status <= lmdd_pkg::ST_ERROR;
          end else begin
            lock_held[lock_count[LCW-2:0]]      <= 1'b0;
            lock_owner[lock_count[LCW-2:0]]     <= 4'd0;
            queue_nonempty[lock_count[LCW-2:0]] <= 1'b0;
            rsp.new_lock_id <= 4'(lock_count);
            lock_count <= lock_count + 1'b1;
          end
        end else if (err) begin
          rsp.status <= lmdd_pkg::ST_ERROR;
        end else begin
          case (r.opcode)
            lmdd_pkg::OP_ACQUIRE: begin
              if (!lock_held[r.lock_id]) begin
                lock_held[r.lock_id]  <= 1'b1;
                lock_owner[r.lock_id] <= r.pid;
              end else begin
                if (queue_nonempty[r.lock_id]) begin
                  if (32'(tail) < NUM_PROCS) proc_next[tail] <= r.pid;
                end else begin
                  queue_head[r.lock_id]     <= r.pid;
                  queue_nonempty[r.lock_id] <= 1'b1;
                end
                queue_tail[r.lock_id]  <= r.pid;
                proc_waiting[r.pid]    <= 1'b1;
                proc_wait_lock[r.pid]  <= r.lock_id;
                rsp.status <= lmdd_pkg::ST_BLOCKED;
                walk_lock  <= r.lock_id;
                walk_cnt   <= '0;
              end
            end
            lmdd_pkg::OP_RELEASE: begin
              if (!queue_nonempty[r.lock_id]) begin
                lock_held[r.lock_id]  <= 1'b0;
                lock_owner[r.lock_id] <= 4'd0;
              end else begin
                if ((head == tail) || (32'(head) >= NUM_PROCS))
                  queue_nonempty[r.lock_id] <= 1'b0;
                else
                  queue_head[r.lock_id] <= proc_next[head];
                lock_held[r.lock_id]  <= 1'b1;
                lock_owner[r.lock_id] <= head;
                if (32'(head) < NUM_PROCS) proc_waiting[head] <= 1'b0;
                rsp.woke      <= 1'b1;
                rsp.woken_pid <= head;
              end
            end
            lmdd_pkg::OP_TRY: begin
              if (!lock_held[r.lock_id]) begin
                lock_held[r.lock_id]  <= 1'b1;
                lock_owner[r.lock_id] <= r.pid;
              end else begin
                rsp.status <= lmdd_pkg::ST_TRYFAIL;
              end
            end
            default: rsp.status <= lmdd_pkg::ST_ERROR;
          endcase
        end
      end
      if (cmd.walk_step) begin
        if (w_lk_ok && own_w != 4'd0 && own_w == r.pid) rsp.deadlock <= 1'b1;
        if (!sts.walk_done) begin
          walk_lock <= proc_wait_lock[own_w];
          walk_cnt  <= walk_cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/lock_manager_deadlock_detect_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_manager_deadlock_detect_core: hardware lock manager with deadlock
// detection on the wait-for graph.
//
// An item (create, acquire, release or try-acquire from one process) is
// accepted at a clock edge where start is high and busy is low. Busy rises
// the next cycle and stays high until the result is shown. The result item
// appears on the result port, marked by done for exactly one cycle; the
// receiver cannot stall, so it must take it in that cycle.
//
// Create, release, try, granted acquires and errors pass through the execute
// state only. A blocked acquire also walks the chain owner -> awaited lock ->
// owner one lock per cycle in the datapath, visiting at most MAX_LOCKS locks.
// One item is taken at a time: busy falls in the cycle the result is shown,
// so the next item can be accepted at the edge that takes the result.
//
// Synchronous reset clears the lock count, held bits, queue flags and
// waiting flags; queue links are only read after they are written.
// ----------------------------------------------------------------------------
module lock_manager_deadlock_detect_core #(
  parameter int MAX_LOCKS = 16,
  parameter int NUM_PROCS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lmdd_pkg::req_t  req,
  output logic            done,
  output lmdd_pkg::rsp_t  rsp
);

  lmdd_pkg::cmd_t cmd;
  lmdd_pkg::sts_t sts;

  // The controller sequences each item; the datapath holds all tables.
  lmdd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  lmdd_dpath #(
    .MAX_LOCKS (MAX_LOCKS),
    .NUM_PROCS (NUM_PROCS)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule
